/* hw/rtl/swfd_pkg.sv */
// ----------------------------------------------------------------------------
// swfd_pkg
// Shared types and constants of the sync word frame deframer.
// ----------------------------------------------------------------------------
package swfd_pkg;

    localparam logic [31:0] SYNC_RESET    = 32'hDEAD_BEEF;
    localparam int          WINDOW_BYTES  = 4;
    localparam logic [3:0]  HEADER_LAST   = 4'd11;

    typedef struct packed {
        logic shift;
        logic clear;
    } hunt_ctrl_t;

endpackage

/* hw/rtl/swfd_sync_hunter.sv */
// ----------------------------------------------------------------------------
// swfd_sync_hunter
// Sliding four-byte little-endian window with fill count and sync compare.
// ----------------------------------------------------------------------------
module swfd_sync_hunter (
    input  logic                clk,
    input  logic                rst_n,
    input  swfd_pkg::hunt_ctrl_t ctrl,
    input  logic [7:0]          stream_byte,
    input  logic [31:0]         sync_word,
    output logic                match
);

    logic [31:0] window_reg;
    logic [31:0] window_next;
    logic [2:0]  fill_reg;
    logic [2:0]  fill_next;

    assign window_next = {stream_byte, window_reg[31:8]};
    assign fill_next   = (fill_reg < 3'(swfd_pkg::WINDOW_BYTES)) ? fill_reg + 3'd1 : fill_reg;
    assign match       = (fill_next >= 3'(swfd_pkg::WINDOW_BYTES)) && (window_next == sync_word);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
        end
        else if (ctrl.clear)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
        end
        else if (ctrl.shift)
        begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

/* hw/rtl/sync_word_frame_deframer_core.sv */
// ----------------------------------------------------------------------------
// sync_word_frame_deframer_core
// Hunts for a sync word in a byte stream, collects a twelve-byte header and
// streams out the tagged payload bytes of each frame, or one empty-frame result.
// ----------------------------------------------------------------------------
//  Channel  | Handshake              | Payload
//  ---------+------------------------+------------------------------------------
//  input    | in_valid / in_ready    | stream_byte
//  result   | out_valid / out_ready  | payload_byte, stamp_seconds, stamp_micros,
//           |                        | frame_length, empty_frame, last_of_frame
//  config   | cfg_write_en           | cfg_write_data (sync word)
//
//  One item is accepted per cycle while in_ready is high; its result, if any,
//  appears in the result register on the following cycle.
//  The throughput is set by the single result register: an item is taken
//  whenever that register is empty or being emptied in the same cycle.
//  Reset leaves the block hunting with an empty window and the sync word
//  at its default value.
// ----------------------------------------------------------------------------
module sync_word_frame_deframer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  payload_byte,
    output logic [31:0] stamp_seconds,
    output logic [31:0] stamp_micros,
    output logic [31:0] frame_length,
    output logic        empty_frame,
    output logic        last_of_frame,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data
);

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [31:0] seconds_reg, seconds_next;
    logic [31:0] micros_reg, micros_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] sync_word_reg;

    logic        out_valid_reg;
    logic [7:0]  byte_reg;
    logic [31:0] o_seconds_reg, o_micros_reg, o_length_reg;
    logic        empty_reg, last_reg;

    logic        accept;
    logic        res_fire;
    logic [7:0]  res_byte;
    logic        res_empty;
    logic        res_last;
    logic [3:0]  idx;
    logic        match;

    swfd_pkg::hunt_ctrl_t hunt_ctrl;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    swfd_sync_hunter u_hunter (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (hunt_ctrl),
        .stream_byte (stream_byte),
        .sync_word   (sync_word_reg),
        .match       (match)
    );

    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        seconds_next    = seconds_reg;
        micros_next     = micros_reg;
        length_next     = length_reg;
        left_next       = left_reg;
        hunt_ctrl.shift = 1'b0;
        hunt_ctrl.clear = 1'b0;
        res_fire        = 1'b0;
        res_byte        = stream_byte;
        res_empty       = 1'b0;
        res_last        = 1'b0;
        idx             = (count_reg > swfd_pkg::HEADER_LAST) ? swfd_pkg::HEADER_LAST
                                                              : count_reg;
        case (phase_reg)
            PH_HEADER:
            begin
                if (accept)
                begin
                    case (idx[3:2])
                        2'd0:    seconds_next[{idx[1:0], 3'b000} +: 8] = stream_byte;
                        2'd1:    micros_next[{idx[1:0], 3'b000} +: 8]  = stream_byte;
                        default: length_next[{idx[1:0], 3'b000} +: 8]  = stream_byte;
                    endcase
                    if (idx >= swfd_pkg::HEADER_LAST)
                    begin
                        count_next = '0;
                        if (length_next == 32'd0)
                        begin
                            res_fire        = 1'b1;
                            res_byte        = 8'd0;
                            res_empty       = 1'b1;
                            res_last        = 1'b1;
                            phase_next      = PH_HUNT;
                            hunt_ctrl.clear = 1'b1;
                        end
                        else
                        begin
                            left_next  = length_next;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        count_next = idx + 4'd1;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (accept)
                begin
                    left_next = left_reg - 32'd1;
                    res_fire  = 1'b1;
                    res_last  = (left_next == 32'd0);
                    if (res_last)
                    begin
                        phase_next      = PH_HUNT;
                        count_next      = '0;
                        hunt_ctrl.clear = 1'b1;
                    end
                end
            end
            default:
            begin
                if (accept)
                begin
                    phase_next      = PH_HUNT;
                    hunt_ctrl.shift = 1'b1;
                    if (match)
                    begin
                        phase_next   = PH_HEADER;
                        count_next   = '0;
                        seconds_next = '0;
                        micros_next  = '0;
                        length_next  = '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            count_reg     <= '0;
            seconds_reg   <= '0;
            micros_reg    <= '0;
            length_reg    <= '0;
            left_reg      <= '0;
            sync_word_reg <= swfd_pkg::SYNC_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            seconds_reg <= seconds_next;
            micros_reg  <= micros_next;
            length_reg  <= length_next;
            left_reg    <= left_next;
            if (cfg_write_en)
            begin
                sync_word_reg <= cfg_write_data;
            end
            if (accept && res_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_fire)
        begin
            byte_reg      <= res_byte;
            o_seconds_reg <= seconds_next;
            o_micros_reg  <= micros_next;
            o_length_reg  <= length_next;
            empty_reg     <= res_empty;
            last_reg      <= res_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_byte  = byte_reg;
    assign stamp_seconds = o_seconds_reg;
    assign stamp_micros  = o_micros_reg;
    assign frame_length  = o_length_reg;
    assign empty_frame   = empty_reg;
    assign last_of_frame = last_reg;

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && empty_reg) |-> (last_reg && byte_reg == 8'd0))
        else $error("empty frame result without last flag or with payload");

    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (left_reg != 32'd0))
        else $error("payload phase with no bytes left");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= swfd_pkg::HEADER_LAST)
        else $error("header count out of range");

    a_no_result_hunting: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_HUNT) |=> !(out_valid_reg && !$past(out_valid_reg)))
        else $error("result produced while hunting");

endmodule
